>>> sv/probabilistic_set_cover_gain_assert.svh
// Assertion helpers for the probabilistic_set_cover_gain RTL.
`ifndef PROBABILISTIC_SET_COVER_GAIN_ASSERT_SVH
`define PROBABILISTIC_SET_COVER_GAIN_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define PSCG_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pscg assertion failed");

// Next-cycle implication, off while reset is high.
`define PSCG_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pscg assertion failed");

`endif

>>> sv/pscg_pkg.sv
`timescale 1ns / 1ps

package pscg_pkg;

   localparam int DEF_MAX_ITEMS    = 256;
   localparam int DEF_MAX_CONCEPTS = 64;

   localparam int RESULT_W = 38;
   localparam int ACTIVE_W = 7;
   localparam int CSR_W    = 7;

   localparam logic [16:0] ONE_Q16 = 17'h10000;

   localparam logic [2:0] OP_LOAD_PROB   = 3'd0;
   localparam logic [2:0] OP_LOAD_WEIGHT = 3'd1;
   localparam logic [2:0] OP_GAIN        = 3'd2;
   localparam logic [2:0] OP_ADD         = 3'd3;
   localparam logic [2:0] OP_EVAL        = 3'd4;
   localparam logic [2:0] OP_CLEAR       = 3'd5;

   localparam logic CSR_ACTIVE = 1'b0;
   localparam logic CSR_CHECK  = 1'b1;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  item;
      logic [5:0]  concept;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic [RESULT_W-1:0] result_value;
      logic                already_selected;
   } rsp_type;

   typedef enum logic [1:0] {
      MUL_WU  = 2'd0,   // weight * uncovered
      MUL_WUP = 2'd1,   // (weight * uncovered) * prob
      MUL_UK  = 2'd2,   // uncovered * (1 - prob)
      MUL_WE  = 2'd3    // weight * (1 - uncovered)
   } mul_sel_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        acc_clr;
      logic        acc_en;
      logic        acc_shift;
   } mac_ctrl_type;

endpackage

>>> sv/pscg_ram.sv
`timescale 1ns / 1ps

module pscg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/pscg_mac.sv
`timescale 1ns / 1ps

module pscg_mac
   import pscg_pkg::*;
(
   input  logic                clock,
   input  mac_ctrl_type        ctrl,
   input  logic [15:0]         weight,
   input  logic [16:0]         uncov,
   input  logic [15:0]         prob,
   output logic [16:0]         uncov_next,
   output logic [RESULT_W-1:0] acc
);

   logic [32:0]         mul_a;
   logic [16:0]         mul_b;
   logic [49:0]         mul_full;
   logic [48:0]         prod_ff, prod_in;
   logic [32:0]         term;
   logic [RESULT_W-1:0] acc_ff, acc_in;

   always_comb begin
      case (ctrl.mul_sel)
         MUL_WU: begin
            mul_a = {17'b0, weight};
            mul_b = uncov;
         end
         MUL_WUP: begin
            mul_a = prod_ff[32:0];
            mul_b = {1'b0, prob};
         end
         MUL_UK: begin
            mul_a = {16'b0, uncov};
            mul_b = ONE_Q16 - {1'b0, prob};
         end
         MUL_WE: begin
            mul_a = {17'b0, weight};
            mul_b = ONE_Q16 - uncov;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = {17'b0, mul_a} * {33'b0, mul_b};
   assign prod_in  = mul_full[48:0];

   // gain terms drop 16 fraction bits, evaluate terms are already Q.16
   assign term = ctrl.acc_shift ? prod_ff[48:16] : prod_ff[32:0];

   always_comb begin
      if (ctrl.acc_clr) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + {{(RESULT_W - 33){1'b0}}, term};
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign uncov_next = prod_ff[32:16];
   assign acc        = acc_ff;

endmodule

>>> sv/probabilistic_set_cover_gain.sv
`timescale 1ns / 1ps

// Weighted probabilistic set cover engine with one shared multiplier. Load prob,
// load weight and clear never raise busy. With n the active concept count
// (capped at MAX_CONCEPTS), a gain query runs RD, M1, M2, M3 per concept
// and an evaluate runs RD, M1, M2, both then FIN, the result strobe coming as
// busy falls; an add item runs RD, M1, M2 per concept, with no result.
// Each concept costs one registered RAM read plus one multiplier pass per product
// (two for gain). Gain queries of items out of range or already selected (with
// checking on), and gain or evaluate with n of zero, answer without going busy.
// rsp_valid is high for exactly one cycle per result and cannot be held off.
module probabilistic_set_cover_gain
   import pscg_pkg::*;
#(
   parameter int MAX_ITEMS    = DEF_MAX_ITEMS,
   parameter int MAX_CONCEPTS = DEF_MAX_CONCEPTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  req_type          req_data,
   output logic             busy,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

`include "probabilistic_set_cover_gain_assert.svh"

   localparam int ITEM_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CONC_W     = (MAX_CONCEPTS > 1) ? $clog2(MAX_CONCEPTS) : 1;
   localparam int NUM_W      = $clog2(MAX_CONCEPTS + 1);
   localparam int PROB_DEPTH = MAX_ITEMS * MAX_CONCEPTS;
   localparam int PADDR_W    = (PROB_DEPTH > 1) ? $clog2(PROB_DEPTH) : 1;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_RD   = 6'b000010,
      S_M1   = 6'b000100,
      S_M2   = 6'b001000,
      S_M3   = 6'b010000,
      S_FIN  = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [2:0]              op_ff, op_in;
   logic [ITEM_W-1:0]       item_ff, item_in;
   logic [CONC_W-1:0]       cnt_ff, cnt_in;
   logic [MAX_ITEMS-1:0]    sel_ff, sel_in;
   logic [MAX_CONCEPTS-1:0] uv_valid_ff, uv_valid_in;
   logic [ACTIVE_W-1:0]     active_ff, active_in;
   logic                    check_ff, check_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    item_ok, concept_ok, sel_hit;
   logic [ITEM_W-1:0]       req_item_idx;
   logic [CONC_W-1:0]       req_conc_idx;
   logic [NUM_W-1:0]        num_concepts;
   logic                    last_concept;

   logic                    prob_we;
   logic [PADDR_W-1:0]      prob_waddr, prob_raddr;
   logic [15:0]             prob_rdata;
   logic                    wt_we;
   logic [15:0]             wt_rdata;
   logic                    uv_we;
   logic [16:0]             uv_rdata, uv_eff, uv_next;
   logic [RESULT_W-1:0]     acc;
   mac_ctrl_type            mac_ctrl;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign item_ok      = 32'(req_data.item) < 32'(MAX_ITEMS);
   assign concept_ok   = 32'(req_data.concept) < 32'(MAX_CONCEPTS);
   assign req_item_idx = ITEM_W'(req_data.item);
   assign req_conc_idx = CONC_W'(req_data.concept);
   assign sel_hit      = sel_ff[req_item_idx];

   assign num_concepts = (32'(active_ff) > 32'(MAX_CONCEPTS)) ?
                         NUM_W'(MAX_CONCEPTS) : NUM_W'(active_ff);
   assign last_concept = (NUM_W'(cnt_ff) == num_concepts - NUM_W'(1));

   // ---- storage ----
   assign prob_we    = accept && (req_data.op == OP_LOAD_PROB) && item_ok && concept_ok;
   assign prob_waddr = PADDR_W'(32'(req_item_idx) * 32'(MAX_CONCEPTS) + 32'(req_conc_idx));
   assign prob_raddr = PADDR_W'(32'(item_ff) * 32'(MAX_CONCEPTS) + 32'(cnt_ff));

   pscg_ram #(
      .WIDTH (16),
      .DEPTH (PROB_DEPTH)
   ) u_prob_ram (
      .clock (clock),
      .we    (prob_we),
      .waddr (prob_waddr),
      .wdata (req_data.value),
      .raddr (prob_raddr),
      .rdata (prob_rdata)
   );

   assign wt_we = accept && (req_data.op == OP_LOAD_WEIGHT) && concept_ok;

   pscg_ram #(
      .WIDTH (16),
      .DEPTH (MAX_CONCEPTS)
   ) u_weight_ram (
      .clock (clock),
      .we    (wt_we),
      .waddr (req_conc_idx),
      .wdata (req_data.value),
      .raddr (cnt_ff),
      .rdata (wt_rdata)
   );

   pscg_ram #(
      .WIDTH (17),
      .DEPTH (MAX_CONCEPTS)
   ) u_uncov_ram (
      .clock (clock),
      .we    (uv_we),
      .waddr (cnt_ff),
      .wdata (uv_next),
      .raddr (cnt_ff),
      .rdata (uv_rdata)
   );

   // never-written products read as 1.0
   assign uv_eff = uv_valid_ff[cnt_ff] ? uv_rdata : ONE_Q16;

   pscg_mac u_mac (
      .clock      (clock),
      .ctrl       (mac_ctrl),
      .weight     (wt_rdata),
      .uncov      (uv_eff),
      .prob       (prob_rdata),
      .uncov_next (uv_next),
      .acc        (acc)
   );

   // ---- sequencer ----
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      item_in      = item_ff;
      cnt_in       = cnt_ff;
      sel_in       = sel_ff;
      uv_valid_in  = uv_valid_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      uv_we        = 1'b0;
      mac_ctrl     = '{mul_sel: MUL_WU, acc_clr: 1'b0, acc_en: 1'b0, acc_shift: 1'b0};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = req_data.op;
               item_in = req_item_idx;
               cnt_in  = '0;
               mac_ctrl.acc_clr = 1'b1;
               case (req_data.op)
                  OP_GAIN: begin
                     if (!item_ok) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{result_value: '0, already_selected: 1'b0};
                     end else if (check_ff && sel_hit) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{result_value: '0, already_selected: 1'b1};
                     end else if (num_concepts == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{result_value: '0, already_selected: 1'b0};
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  OP_ADD: begin
                     if (item_ok && !sel_hit) begin
                        sel_in[req_item_idx] = 1'b1;
                        if (num_concepts != '0) begin
                           state_in = S_RD;
                        end
                     end
                  end
                  OP_EVAL: begin
                     if (num_concepts == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{result_value: '0, already_selected: 1'b0};
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  OP_CLEAR: begin
                     sel_in      = '0;
                     uv_valid_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD: begin
            state_in = S_M1;
         end
         S_M1: begin
            case (op_ff)
               OP_GAIN: mac_ctrl.mul_sel = MUL_WU;
               OP_ADD:  mac_ctrl.mul_sel = MUL_UK;
               default: mac_ctrl.mul_sel = MUL_WE;
            endcase
            state_in = S_M2;
         end
         S_M2: begin
            case (op_ff)
               OP_GAIN: begin
                  mac_ctrl.mul_sel = MUL_WUP;
                  state_in = S_M3;
               end
               OP_ADD: begin
                  uv_we = 1'b1;
                  uv_valid_in[cnt_ff] = 1'b1;
                  state_in = last_concept ? S_IDLE : S_RD;
                  cnt_in   = cnt_ff + CONC_W'(1);
               end
               default: begin
                  mac_ctrl.acc_en = 1'b1;
                  state_in = last_concept ? S_FIN : S_RD;
                  cnt_in   = cnt_ff + CONC_W'(1);
               end
            endcase
         end
         S_M3: begin
            mac_ctrl.acc_en    = 1'b1;
            mac_ctrl.acc_shift = 1'b1;
            state_in = last_concept ? S_FIN : S_RD;
            cnt_in   = cnt_ff + CONC_W'(1);
         end
         S_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{result_value: acc, already_selected: 1'b0};
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      active_in = active_ff;
      check_in  = check_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ACTIVE: active_in = csr_wdata[ACTIVE_W-1:0];
            CSR_CHECK:  check_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= '0;
         uv_valid_ff  <= '0;
         active_ff    <= ACTIVE_W'(64);
         check_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         uv_valid_ff  <= uv_valid_in;
         active_ff    <= active_in;
         check_ff     <= check_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      item_ff     <= item_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- assertions ----
   `PSCG_ASSERT_IMP(a_rsp_only_idle, clock, reset, rsp_valid, !busy)
   `PSCG_ASSERT_IMP(a_selected_zero, clock, reset,
      rsp_valid && rsp_data.already_selected, rsp_data.result_value == '0)
   `PSCG_ASSERT_IMP(a_cnt_in_range, clock, reset,
      state_ff == S_RD, NUM_W'(cnt_ff) < num_concepts)
   `PSCG_ASSERT_IMP(a_add_marked, clock, reset,
      state_ff == S_RD && op_ff == OP_ADD, sel_ff[item_ff])
   `PSCG_ASSERT_NEXT(a_clear_empties, clock, reset,
      accept && req_data.op == OP_CLEAR, sel_ff == '0 && uv_valid_ff == '0)

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import pscg_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 7;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 85;
   localparam int CALM_TAIL     = 150;
   localparam int CSR_SETTLE    = 4 * DEF_MAX_CONCEPTS + 4;
   localparam int DRAIN_CYCLES  = 300;
   localparam int QUIET_LIMIT   = 4000;
   localparam int MAX_PRINTED   = 100;

   // op codes the block does not decode
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   typedef struct {
      bit               is_csr;
      req_type          req;
      logic             csr_idx;
      logic [CSR_W-1:0] csr_val;
   } stim_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   req_type          req_data  = '0;
   logic             busy;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_we    = 1'b0;
   logic             csr_index = 1'b0;
   logic [CSR_W-1:0] csr_wdata = '0;

   probabilistic_set_cover_gain dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // ---------------- cover state mirror ----------------
   bit [15:0]   prob_mem [DEF_MAX_ITEMS*DEF_MAX_CONCEPTS];
   bit [15:0]   weight_mem [DEF_MAX_CONCEPTS];
   bit [16:0]   uncov [DEF_MAX_CONCEPTS];
   bit          picked [DEF_MAX_ITEMS];
   int unsigned active_cfg;
   bit          check_cfg;
   rsp_type     gain_eval_due [$];

   stim_type    pending [$];
   bit          row_written [DEF_MAX_ITEMS][DEF_MAX_CONCEPTS];
   int          gen_n;

   bit          req_taken;
   int          quiet_cycles;
   int          idle_left;
   int          settle;
   int          mismatches;

   task automatic clear_cover();
      for (int c = 0; c < DEF_MAX_CONCEPTS; c++) uncov[c] = ONE_Q16;
      for (int i = 0; i < DEF_MAX_ITEMS; i++) picked[i] = 1'b0;
   endtask

   task automatic cover_step(input req_type r);
      int unsigned     n;
      longint unsigned acc;
      longint unsigned wu;
      longint unsigned prob;
      int              row;
      rsp_type         res;
      n   = (active_cfg > DEF_MAX_CONCEPTS) ? DEF_MAX_CONCEPTS : active_cfg;
      acc = 0;
      res = '0;
      row = int'(r.item) * DEF_MAX_CONCEPTS;
      case (r.op)
         OP_LOAD_PROB: prob_mem[row + int'(r.concept)] = r.value;
         OP_LOAD_WEIGHT: weight_mem[r.concept] = r.value;
         OP_GAIN: begin
            if (check_cfg && picked[r.item]) begin
               res.already_selected = 1'b1;
            end else begin
               for (int c = 0; c < n; c++) begin
                  wu   = longint'(weight_mem[c]) * longint'(uncov[c]);
                  prob = prob_mem[row + c];
                  acc += (wu * prob) >> 16;
               end
               res.result_value = acc[RESULT_W-1:0];
            end
            gain_eval_due.push_back(res);
         end
         OP_ADD: begin
            if (!picked[r.item]) begin
               for (int c = 0; c < n; c++) begin
                  prob   = longint'(ONE_Q16) - prob_mem[row + c];
                  wu     = (longint'(uncov[c]) * prob) >> 16;
                  uncov[c] = wu[16:0];
               end
               picked[r.item] = 1'b1;
            end
         end
         OP_EVAL: begin
            for (int c = 0; c < n; c++)
               acc += longint'(weight_mem[c]) * (longint'(ONE_Q16) - longint'(uncov[c]));
            res.result_value = acc[RESULT_W-1:0];
            gain_eval_due.push_back(res);
         end
         OP_CLEAR: clear_cover();
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (mismatches < MAX_PRINTED)
         $display("testbench: mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
      mismatches++;
   endtask

   // ---------------- stimulus construction ----------------
   function automatic logic [15:0] rand16();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 255));
         3:       return 16'($urandom_range(65280, 65535));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic bit row_ready(input int item, input int n);
      for (int c = 0; c < n; c++)
         if (!row_written[item][c]) return 1'b0;
      return 1'b1;
   endfunction

   // gain and add only touch rows that are loaded for every active concept
   function automatic int pick_item(input int n);
      int cand;
      for (int k = 0; k < 8; k++) begin
         cand = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
         if (row_ready(cand, n)) return cand;
      end
      return $urandom_range(0, 3);
   endfunction

   task automatic push_req(input logic [2:0] op, input int item, input int concept,
                           input logic [15:0] value);
      stim_type s;
      s.is_csr    = 1'b0;
      s.req.op      = op;
      s.req.item    = 8'(item);
      s.req.concept = 6'(concept);
      s.req.value   = value;
      s.csr_idx   = CSR_ACTIVE;
      s.csr_val   = '0;
      if (op == OP_LOAD_PROB) row_written[item][concept] = 1'b1;
      pending.push_back(s);
   endtask

   task automatic push_csr(input logic idx, input int val);
      stim_type s;
      s.is_csr  = 1'b1;
      s.req     = '0;
      s.csr_idx = idx;
      s.csr_val = CSR_W'(val);
      if (idx == CSR_ACTIVE) gen_n = (val > DEF_MAX_CONCEPTS) ? DEF_MAX_CONCEPTS : val;
      pending.push_back(s);
   endtask

   task automatic push_free(input logic [2:0] op, input int item);
      push_req(op, item, $urandom_range(0, 63), 16'($urandom));
   endtask

   // ---------------- driver ----------------
   always @(negedge clock) begin : driver
      stim_type         head;
      logic             start_nx;
      req_type          data_nx;
      logic             we_nx;
      logic             idx_nx;
      logic [CSR_W-1:0] wd_nx;
      start_nx = start;
      data_nx  = req_data;
      we_nx    = 1'b0;
      idx_nx   = csr_index;
      wd_nx    = csr_wdata;
      if (!reset && !(start && !req_taken)) begin
         start_nx = 1'b0;
         if (idle_left > 0) begin
            idle_left--;
         end else if (pending.size() > 0) begin
            if (pending[0].is_csr) begin
               // registers change only once the block has drained
               if (gain_eval_due.size() == 0 && !busy && !start) settle++;
               else settle = 0;
               if (settle >= CSR_SETTLE) begin
                  head   = pending.pop_front();
                  we_nx  = 1'b1;
                  idx_nx = head.csr_idx;
                  wd_nx  = head.csr_val;
                  settle = 0;
               end
            end else begin
               head     = pending.pop_front();
               start_nx = 1'b1;
               data_nx  = head.req;
               if (pending.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
                  idle_left = $urandom_range(1, 11);
            end
         end
      end
      start     <= start_nx;
      req_data  <= data_nx;
      csr_we    <= we_nx;
      csr_index <= idx_nx;
      csr_wdata <= wd_nx;
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin : monitor
      rsp_type due;
      if (reset) begin
         clear_cover();
         active_cfg   = DEF_MAX_CONCEPTS;
         check_cfg    = 1'b1;
         req_taken    = 1'b0;
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (rsp_valid) begin
            quiet_cycles = 0;
            if (gain_eval_due.size() == 0) begin
               report_mismatch("unexpected result", rsp_data.result_value, 0);
            end else begin
               due = gain_eval_due.pop_front();
               if (rsp_data.result_value !== due.result_value)
                  report_mismatch("result_value", rsp_data.result_value, due.result_value);
               if (rsp_data.already_selected !== due.already_selected)
                  report_mismatch("already_selected", rsp_data.already_selected,
                                  due.already_selected);
            end
         end
         if (csr_we) begin
            quiet_cycles = 0;
            if (csr_index == CSR_ACTIVE) active_cfg = csr_wdata;
            else check_cfg = csr_wdata[0];
         end
         req_taken = start && !busy;
         if (req_taken) begin
            quiet_cycles = 0;
            cover_step(req_data);
         end
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("testbench: FAIL");
      $finish;
   end

   // ---------------- sequence ----------------
   int phase_active [PHASES] = '{64, 1, 3, 8, 0, 127, 5, 64, 2, 16, 4, 65};
   bit phase_check  [PHASES] = '{1, 1, 0, 1, 0, 0, 1, 1, 0, 1, 0, 1};

   initial begin : sequencer
      int n_items;
      int sel;
      int it;
      int cc;
      mismatches = 0;
      idle_left  = 0;
      settle     = 0;
      gen_n      = DEF_MAX_CONCEPTS;

      // table preload: full-scale weights, rows 0..3 complete
      for (int c = 0; c < DEF_MAX_CONCEPTS; c++) begin
         push_req(OP_LOAD_WEIGHT, $urandom_range(0, 255), c, 16'hFFFF);
         push_req(OP_LOAD_PROB, 0, c, 16'hFFFF);
         push_req(OP_LOAD_PROB, 1, c, 16'h0000);
         push_req(OP_LOAD_PROB, 2, c, rand16());
         push_req(OP_LOAD_PROB, 3, c, rand16());
      end

      // directed: empty selection, largest gain, selected item, spare ops
      push_free(OP_EVAL, 0);
      push_free(OP_GAIN, 0);
      push_free(OP_GAIN, 1);
      push_free(OP_ADD, 0);
      push_free(OP_GAIN, 0);
      push_free(OP_ADD, 0);
      push_free(OP_EVAL, 0);
      push_free(OP_ADD, 2);
      push_free(OP_GAIN, 3);
      push_free(OP_SPARE_A, 255);
      push_free(OP_SPARE_B, 0);
      push_req(OP_LOAD_PROB, 255, 63, 16'hFFFF);
      push_req(OP_LOAD_WEIGHT, 0, 0, 16'h0000);
      push_free(OP_CLEAR, 0);
      push_free(OP_EVAL, 0);
      push_csr(CSR_CHECK, 0);
      push_free(OP_ADD, 3);
      push_free(OP_GAIN, 3);
      // zero active concepts: nothing is read, add touches only the bitmap
      push_csr(CSR_ACTIVE, 0);
      push_csr(CSR_CHECK, 1);
      push_free(OP_GAIN, 5);
      push_free(OP_ADD, 200);
      push_free(OP_GAIN, 200);
      push_free(OP_EVAL, 0);
      // count above the table size saturates
      push_csr(CSR_ACTIVE, 127);
      push_csr(CSR_CHECK, 0);
      push_free(OP_GAIN, 2);
      push_free(OP_EVAL, 0);
      push_free(OP_CLEAR, 0);

      for (int p = 0; p < PHASES; p++) begin
         push_csr(CSR_ACTIVE, phase_active[p]);
         push_csr(CSR_CHECK, phase_check[p]);
         n_items = 0;
         while (n_items < PHASE_ITEMS) begin
            sel = $urandom_range(0, 99);
            n_items++;
            if (sel < 28) begin
               it = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 255);
               cc = (gen_n > 0 && $urandom_range(0, 9) < 7) ? $urandom_range(0, gen_n - 1)
                                                          : $urandom_range(0, 63);
               push_req(OP_LOAD_PROB, it, cc, rand16());
            end else if (sel < 36) begin
               push_req(OP_LOAD_WEIGHT, $urandom_range(0, 255), $urandom_range(0, 63), rand16());
            end else if (sel < 62) begin
               push_free(OP_GAIN, pick_item(gen_n));
            end else if (sel < 80) begin
               push_free(OP_ADD, pick_item(gen_n));
            end else if (sel < 91) begin
               push_free(OP_EVAL, $urandom_range(0, 255));
            end else if (sel < 96) begin
               push_free(OP_CLEAR, $urandom_range(0, 255));
            end else begin
               push_free(($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B,
                         $urandom_range(0, 255));
               n_items--;
            end
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || start || gain_eval_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (gain_eval_due.size() != 0)
         report_mismatch("missing result", 0, gain_eval_due.size());

      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

>>> probabilistic_set_cover_gain.f
+incdir+sv
sv/pscg_pkg.sv
sv/pscg_ram.sv
sv/pscg_mac.sv
sv/probabilistic_set_cover_gain.sv
tb/testbench.sv
